[sv/mlft_pkg.sv]
package mlft_pkg;

    localparam logic [15:0] ETH_ARP    = 16'd2054;
    localparam logic [15:0] ETH_IPV4   = 16'd2048;
    localparam logic [15:0] PRIO_START = 16'd100;
    localparam logic [15:0] PRIO_MAX   = 16'd65535;
    localparam logic [47:0] MAC_BCAST  = 48'hFFFF_FFFF_FFFF;

    localparam logic CMD_PACKET       = 1'b0;
    localparam logic CMD_FLOW_REMOVED = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  switch_index;
        logic        is_no_match;
        logic [7:0]  ingress_port;
        logic [47:0] source_mac;
        logic [47:0] dest_mac;
        logic        dest_mac_present;
        logic        ethertype_present;
        logic [15:0] ethertype;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  egress_port;
        logic        flood;
        logic        learned;
        logic [15:0] rule_priority;
        logic        table_full;
    } t_out_item;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;      // input side may accept
        logic accept;    // item accepted this edge
        logic clear_wr;  // clearing pass write
        logic scan;      // issue next table read
        logic commit;    // apply table update and load result
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic live;       // item needs a table pass
        logic scan_done;  // last entry compared
        logic needs_out;  // item produces a result
        logic out_free;   // output register can take a result
    } t_dp_stat;

endpackage

[sv/mlft_ctrl.sv]
module mlft_ctrl
    import mlft_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.take = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_stat.live) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.scan = 1'b1;
                    if (i_stat.scan_done) begin
                        n_state = S_COMMIT;
                    end
                end
            end
            S_COMMIT: begin
                if (!i_stat.needs_out || i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

[sv/mlft_dp.sv]
module mlft_dp
    import mlft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int SWITCH_COUNT  = 4,
    parameter int PORT_BITS     = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl_cmd i_cmd,
    output t_dp_stat  o_stat,
    input  t_in_item  i_in,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = AW + 1;
    localparam int EW = 1 + 2 + 48 + PORT_BITS;
    localparam logic [CW-1:0] CNT_END   = CW'(TABLE_ENTRIES);
    localparam logic [CW-1:0] CNT_LAST  = CW'(TABLE_ENTRIES - 1);
    localparam logic [AW-1:0] IDX_LAST  = AW'(TABLE_ENTRIES - 1);
    localparam logic [31:0]   SW_LIMIT  = 32'(SWITCH_COUNT);

    // entry: valid | switch | mac | port
    logic [EW-1:0] mem [TABLE_ENTRIES];

    t_in_item             r_item;
    logic                 r_live;
    logic [CW-1:0]        r_cnt;
    logic                 r_cmp_vld;
    logic [AW-1:0]        r_cmp_idx;
    logic [EW-1:0]        r_rd;
    logic                 r_src_hit;
    logic                 r_dst_hit;
    logic [AW-1:0]        r_dst_idx;
    logic [PORT_BITS-1:0] r_dst_port;
    logic                 r_free_found;
    logic [AW-1:0]        r_free_idx;
    logic [15:0]          r_prio;
    logic                 r_out_vld;
    t_out_item            r_out;

    logic                      in_sw_ok;
    logic                      in_et_skip;
    logic                      in_live;
    logic                      rd_en;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [EW-1:0]             wr_data;
    logic                      ent_v;
    logic [1:0]                ent_sw;
    logic [47:0]               ent_mac;
    logic [PORT_BITS-1:0]      ent_port;
    logic                      ent_sw_eq;
    logic [PORT_BITS+7:0]      port_ext;
    logic [PORT_BITS-1:0]      port_st;
    logic                      learn_need;
    logic                      do_learn;
    logic [15:0]               prio_next;
    logic                      res_flood;
    logic [PORT_BITS-1:0]      res_port;
    logic [PORT_BITS+7:0]      egress_ext;
    t_out_item                 res;
    logic                      out_free;

    // classify incoming item
    always_comb begin
        in_sw_ok   = {30'd0, i_in.switch_index} < SW_LIMIT;
        in_et_skip = i_in.ethertype_present &&
                     ((i_in.ethertype == ETH_ARP) || (i_in.ethertype == ETH_IPV4));
        if (i_in.cmd == CMD_FLOW_REMOVED) begin
            in_live = in_sw_ok && i_in.dest_mac_present;
        end else begin
            in_live = in_sw_ok && i_in.is_no_match && !in_et_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else if (i_cmd.accept) begin
            r_live <= in_live;
        end
    end

    assign rd_en = i_cmd.scan && (r_cnt < CNT_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.accept) begin
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cmd.clear_wr || rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end
            r_cmp_vld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_cnt[AW-1:0];
    end

    // entry fields of the registered read
    always_comb begin
        ent_v     = r_rd[EW-1];
        ent_sw    = r_rd[EW-2 -: 2];
        ent_mac   = r_rd[EW-4 -: 48];
        ent_port  = r_rd[PORT_BITS-1:0];
        ent_sw_eq = ent_v && (ent_sw == r_item.switch_index);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.accept) begin
            r_src_hit    <= 1'b0;
            r_dst_hit    <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_cmp_vld) begin
            if (ent_sw_eq && (ent_mac == r_item.source_mac)) begin
                r_src_hit <= 1'b1;
            end
            if (ent_sw_eq && (ent_mac == r_item.dest_mac)) begin
                r_dst_hit <= 1'b1;
            end
            if (!ent_v && !r_free_found) begin
                r_free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_vld && ent_sw_eq && (ent_mac == r_item.dest_mac)) begin
            r_dst_idx  <= r_cmp_idx;
            r_dst_port <= ent_port;
        end
        if (r_cmp_vld && !ent_v && !r_free_found) begin
            r_free_idx <= r_cmp_idx;
        end
    end

    // learn and lookup decision
    always_comb begin
        port_ext   = {{PORT_BITS{1'b0}}, r_item.ingress_port};
        port_st    = port_ext[PORT_BITS-1:0];
        learn_need = (r_item.source_mac != MAC_BCAST) && !r_src_hit;
        do_learn   = learn_need && r_free_found;
        prio_next  = (r_prio == PRIO_MAX) ? r_prio : (r_prio + 16'd1);

        res_flood = 1'b1;
        res_port  = '0;
        if (r_item.dest_mac != MAC_BCAST) begin
            if (r_dst_hit) begin
                res_flood = 1'b0;
                res_port  = r_dst_port;
            end else if (do_learn && (r_item.dest_mac == r_item.source_mac)) begin
                res_flood = 1'b0;
                res_port  = port_st;
            end
        end
        egress_ext = {8'd0, res_port};

        res.egress_port   = egress_ext[7:0];
        res.flood         = res_flood;
        res.learned       = do_learn;
        res.rule_priority = do_learn ? prio_next : 16'd0;
        res.table_full    = learn_need && !r_free_found;
    end

    // single write port: clearing pass or commit
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cnt[AW-1:0];
        wr_data = '0;
        if (i_cmd.clear_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.commit) begin
            if (r_item.cmd == CMD_FLOW_REMOVED) begin
                wr_en   = r_dst_hit;
                wr_addr = r_dst_idx;
            end else begin
                wr_en   = do_learn;
                wr_addr = r_free_idx;
                wr_data = {1'b1, r_item.switch_index, r_item.source_mac, port_st};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[r_cnt[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio <= PRIO_START;
        end else if (i_cmd.commit && (r_item.cmd == CMD_PACKET) && do_learn) begin
            r_prio <= prio_next;
        end
    end

    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit && (r_item.cmd == CMD_PACKET)) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_item.cmd == CMD_PACKET)) begin
            r_out <= res;
        end
    end

    always_comb begin
        o_stat.clear_last = (r_cnt == CNT_LAST);
        o_stat.live       = r_live;
        o_stat.scan_done  = r_cmp_vld && (r_cmp_idx == IDX_LAST);
        o_stat.needs_out  = (r_item.cmd == CMD_PACKET);
        o_stat.out_free   = out_free;
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

[sv/mac_learning_forwarding_table.sv]
// MAC learning bridge table shared by up to SWITCH_COUNT switches. A table-miss
// packet event (ethertype absent, or neither ARP nor IPv4) learns its source
// address into the lowest free entry, taking a rule priority from a counter
// that starts at 100 and saturates at 65535, then resolves its destination to
// an egress port or flood; one result item follows. A flow-removed event
// erases the matching entry and gives no item. After reset a clearing pass
// writes every entry invalid, with the input stalled. An item that needs the
// table (a table-miss packet that answers, or a flow-removed event carrying an
// address) is not through until the table memory has been read one entry per
// cycle to find source match, destination match and free slot together; the
// next item is taken only after its commit. Items that leave the table alone
// (other packet events, flow-removed without an address, switch out of range)
// skip the scan and commit. A result waits in an output register; the next
// item is taken meanwhile, only its commit waits for the register to drain,
// which adds the downstream stall to that item's time.
module mac_learning_forwarding_table
    import mlft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int SWITCH_COUNT  = 4,
    parameter int PORT_BITS     = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    // sequencer: clear, idle, scan, commit
    mlft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // table memory, compare registers, priority counter, output register
    mlft_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SWITCH_COUNT  (SWITCH_COUNT),
        .PORT_BITS     (PORT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    assign o_in_stall = !cmd.take;

    // a result never both learns and reports a full table
    a_learn_vs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.learned && o_out.table_full))
        else $error("learned and table_full both set");

    // flooding results carry no port
    a_flood_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.flood) |-> (o_out.egress_port == 8'd0))
        else $error("flood with non-zero egress port");

    // a learned entry always reports a priority above the start value
    a_prio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.learned) |-> (o_out.rule_priority > PRIO_START))
        else $error("learned priority not above start value");

    // commit never overwrites a result that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.commit && stat.needs_out) |-> stat.out_free)
        else $error("commit while output register held");

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

// Bench for the MAC learning bridge table.
// Items go in through a valid/stall channel, each one is run through a local
// model of the table (entries, lowest-free-slot allocation, saturating rule
// priority) at the edge where it is accepted, and any result it should give
// is queued. Results coming out are popped and compared field by field.
// Three phases: hand-picked corner items, a fill of the whole table to reach
// the overflow flag followed by a partial erase, and random traffic built
// mostly from a small pool of addresses so that lookups and relearns hit.
module tb
    import mlft_pkg::*;
();

    localparam int TABLE_ENTRIES = 256;
    localparam int SWITCH_COUNT  = 4;
    localparam int PORT_BITS     = 8;
    // an item that needs the table scans every entry, as does the clearing pass
    // after reset; allow plenty on top of that
    localparam int HANG_LIMIT    = 4000;
    localparam int TAIL_CYCLES   = TABLE_ENTRIES + 40;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;

    // local copy of the table
    bit          mac_valid [TABLE_ENTRIES];
    logic [1:0]  mac_sw    [TABLE_ENTRIES];
    logic [47:0] mac_addr  [TABLE_ENTRIES];
    logic [7:0]  mac_port  [TABLE_ENTRIES];
    logic [15:0] rule_prio_count = PRIO_START;

    t_out_item   fwd_expected [$];
    t_out_item   fwd_want;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned tx_idle_max    = 0;
    int unsigned rx_idle_max    = 0;
    int unsigned rx_hold        = 0;

    mac_learning_forwarding_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SWITCH_COUNT  (SWITCH_COUNT),
        .PORT_BITS     (PORT_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Table model
    // ---------------------------------------------------------------
    function automatic int find_entry(logic [1:0] sw, logic [47:0] mac);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (mac_valid[i] && mac_sw[i] == sw && mac_addr[i] == mac) return i;
        end
        return -1;
    endfunction

    function automatic int free_entry();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!mac_valid[i]) return i;
        end
        return -1;
    endfunction

    // Applies one item to the table; returns 1 when the item gives a result.
    function automatic bit forward_decision(input t_in_item it, output t_out_item res);
        int hit;
        int slot;
        res = '0;
        res.flood = 1'b1;
        if (int'(it.switch_index) >= SWITCH_COUNT) return 1'b0;
        if (it.cmd == CMD_FLOW_REMOVED) begin
            if (it.dest_mac_present) begin
                hit = find_entry(it.switch_index, it.dest_mac);
                if (hit >= 0) mac_valid[hit] = 1'b0;
            end
            return 1'b0;
        end
        if (!it.is_no_match) return 1'b0;
        if (it.ethertype_present && (it.ethertype == ETH_ARP || it.ethertype == ETH_IPV4))
            return 1'b0;

        // learn first, so a packet addressed to itself finds its own entry
        if (it.source_mac != MAC_BCAST && find_entry(it.switch_index, it.source_mac) < 0) begin
            slot = free_entry();
            if (slot < 0) begin
                res.table_full = 1'b1;
            end else begin
                mac_valid[slot] = 1'b1;
                mac_sw[slot]    = it.switch_index;
                mac_addr[slot]  = it.source_mac;
                mac_port[slot]  = it.ingress_port;
                if (rule_prio_count != PRIO_MAX) rule_prio_count++;
                res.rule_priority = rule_prio_count;
                res.learned       = 1'b1;
            end
        end

        if (it.dest_mac != MAC_BCAST) begin
            hit = find_entry(it.switch_index, it.dest_mac);
            if (hit >= 0) begin
                res.flood       = 1'b0;
                res.egress_port = mac_port[hit];
            end
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Item builders
    // ---------------------------------------------------------------
    function automatic logic [47:0] rand_mac();
        logic [47:0] m;
        m[31:0]  = $urandom;
        m[47:32] = 16'($urandom);
        return m;
    endfunction

    function automatic t_in_item make_pkt(logic [1:0] sw, logic [7:0] port,
                                          logic [47:0] src, logic [47:0] dst);
        t_in_item it;
        it              = '0;
        it.cmd          = CMD_PACKET;
        it.switch_index = sw;
        it.is_no_match  = 1'b1;
        it.ingress_port = port;
        it.source_mac   = src;
        it.dest_mac     = dst;
        return it;
    endfunction

    function automatic t_in_item make_erase(logic [1:0] sw, logic [47:0] mac, logic present);
        t_in_item it;
        it                  = '0;
        it.cmd              = CMD_FLOW_REMOVED;
        it.switch_index     = sw;
        it.dest_mac         = mac;
        it.dest_mac_present = present;
        return it;
    endfunction

    // ---------------------------------------------------------------
    // Sender: random gap, then hold the item until it is taken. Valid is
    // only lowered when a gap follows, so back-to-back items keep it high.
    // The model is stepped here, at the accepting edge, so the test tasks
    // always see an up-to-date table.
    // ---------------------------------------------------------------
    task automatic send_item(input t_in_item it);
        int unsigned gap;
        t_out_item   res;
        gap = $urandom_range(tx_idle_max, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (forward_decision(it, res)) fwd_expected = {fwd_expected, res};
    endtask

    // ---------------------------------------------------------------
    // Receiver: after each result taken, stall for a drawn number of cycles
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) rx_hold = $urandom_range(rx_idle_max, 0);
            else if (rx_hold > 0) rx_hold--;
            i_out_stall <= (rx_hold > 0);
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (fwd_expected.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result expected none actual %p", $time, o_out);
            end else begin
                fwd_want = fwd_expected.pop_front();
                check_field("egress_port",   fwd_want.egress_port,   o_out.egress_port);
                check_field("flood",         fwd_want.flood,         o_out.flood);
                check_field("learned",       fwd_want.learned,       o_out.learned);
                check_field("rule_priority", fwd_want.rule_priority, o_out.rule_priority);
                check_field("table_full",    fwd_want.table_full,    o_out.table_full);
            end
        end
    end

    // hang detector: nothing accepted on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("[mac_learning_forwarding_table] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_corner_items();
        logic [47:0] mac_a;
        logic [47:0] mac_b;
        logic [47:0] mac_c;
        t_in_item    it;
        mac_a = 48'h0;
        mac_b = 48'h7FFF_FFFF_FFFE;
        mac_c = rand_mac();
        tx_idle_max = 0;
        rx_idle_max = 0;

        send_item(make_pkt(2'd0, 8'd5,   mac_a, mac_b));     // learn, unknown dest
        send_item(make_pkt(2'd0, 8'hFF,  mac_b, mac_a));     // learn, forward to port 5
        send_item(make_pkt(2'd0, 8'd0,   mac_a, mac_b));     // known source, other port: kept
        send_item(make_pkt(2'd3, 8'd9,   mac_a, mac_b));     // same address, other switch
        send_item(make_pkt(2'd0, 8'd7,   MAC_BCAST, mac_a)); // broadcast source not learnt
        send_item(make_pkt(2'd0, 8'd7,   mac_c, MAC_BCAST)); // broadcast dest floods
        send_item(make_pkt(2'd1, 8'd7,   MAC_BCAST, MAC_BCAST));
        send_item(make_pkt(2'd2, 8'd77,  mac_c, mac_c));     // addressed to itself

        tx_idle_max = 5;
        rx_idle_max = 5;
        it = make_pkt(2'd0, 8'd3, mac_a, mac_b);
        it.ethertype_present = 1'b1;
        it.ethertype = ETH_ARP;
        send_item(it);                                       // ARP: silent
        it.ethertype = ETH_IPV4;
        send_item(it);                                       // IPv4: silent
        it.ethertype = ETH_IPV4 + 16'd1;
        send_item(it);                                       // other type answers
        it.ethertype_present = 1'b0;
        it.ethertype = ETH_ARP;
        send_item(it);                                       // ARP value, no field: answers
        it = make_pkt(2'd0, 8'd3, rand_mac(), mac_b);
        it.is_no_match = 1'b0;
        send_item(it);                                       // not a table miss

        send_item(make_erase(2'd0, mac_a, 1'b1));
        send_item(make_pkt(2'd0, 8'd1, mac_b, mac_a));       // erased: floods
        send_item(make_erase(2'd0, mac_b, 1'b0));            // no address carried
        send_item(make_pkt(2'd0, 8'd1, mac_c, mac_b));       // still forwards to 255
        send_item(make_erase(2'd1, mac_b, 1'b1));            // absent on that switch
        send_item(make_erase(2'd0, mac_a, 1'b1));            // already gone
        send_item(make_pkt(2'd3, 8'd2, mac_b, mac_a));       // switch 3 copy intact
        send_item(make_pkt(2'd0, 8'd200, mac_a, mac_a));     // relearn the erased address
    endtask

    task automatic test_table_overflow();
        int guard;
        guard = 0;
        tx_idle_max = 2;
        rx_idle_max = 5;
        // fill every entry with fresh sources, looking up addresses already seen
        while (free_entry() >= 0 && guard < 2 * TABLE_ENTRIES) begin
            send_item(make_pkt(2'($urandom), 8'($urandom), rand_mac(),
                               mac_addr[$urandom_range(TABLE_ENTRIES - 1, 0)]));
            guard++;
        end
        // full: new sources overflow, known and broadcast sources do not
        repeat (3) send_item(make_pkt(2'($urandom), 8'($urandom), rand_mac(), rand_mac()));
        send_item(make_pkt(mac_sw[7], 8'd1, mac_addr[7], mac_addr[9]));
        send_item(make_pkt(mac_sw[9], 8'd1, MAC_BCAST, mac_addr[9]));
        for (int i = 0; i < TABLE_ENTRIES - 16; i += 2)
            send_item(make_erase(mac_sw[i], mac_addr[i], 1'b1));
        send_item(make_pkt(2'd1, 8'h3C, rand_mac(), MAC_BCAST));
    endtask

    task automatic test_random_traffic();
        logic [47:0] pool [16];
        t_in_item    it;
        int unsigned pick;
        for (int i = 0; i < 16; i++) pool[i] = rand_mac();
        pool[0]  = '0;
        pool[15] = MAC_BCAST;
        for (int n = 0; n < 150; n++) begin
            // alternate between busy and relaxed stretches
            if (n % 40 == 0) begin
                tx_idle_max = $urandom_range(1, 0) * 5;
                rx_idle_max = $urandom_range(1, 0) * 5;
            end
            it.cmd               = 1'($urandom);
            it.switch_index      = 2'($urandom);
            it.is_no_match       = 1'($urandom);
            it.ingress_port      = 8'($urandom);
            it.source_mac        = rand_mac();
            it.dest_mac          = rand_mac();
            it.dest_mac_present  = 1'($urandom);
            it.ethertype_present = 1'($urandom);
            it.ethertype         = 16'($urandom);
            pick = $urandom_range(99, 0);
            if (pick < 65) begin
                it.cmd         = CMD_PACKET;
                it.is_no_match = 1'b1;
                it.source_mac  = pool[$urandom_range(15, 0)];
                it.dest_mac    = pool[$urandom_range(15, 0)];
            end else if (pick < 80) begin
                it.cmd              = CMD_FLOW_REMOVED;
                it.dest_mac         = pool[$urandom_range(15, 0)];
                it.dest_mac_present = ($urandom_range(7, 0) != 0);
            end else if (pick < 88) begin
                it.cmd               = CMD_PACKET;
                it.is_no_match       = 1'b1;
                it.ethertype_present = 1'b1;
                it.ethertype         = pick[0] ? ETH_ARP : ETH_IPV4;
            end
            send_item(it);
        end
    endtask

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            mac_valid[i] = 1'b0;
            mac_sw[i]    = '0;
            mac_addr[i]  = '0;
            mac_port[i]  = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_items();
        test_table_overflow();
        test_random_traffic();

        // drain, then give the block time to show anything spurious
        i_in_valid <= 1'b0;
        while (fwd_expected.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[mac_learning_forwarding_table] OK");
        else
            $display("[mac_learning_forwarding_table] ERROR");
        $finish;
    end

endmodule
